### src/gcpb_pkg.sv
// shared constants, types and arithmetic helpers for the glyph coverage pixel blender
package gcpb_pkg;

   // pixel format codes
   localparam logic [1:0] FMT_ARGB32 = 2'd0;
   localparam logic [1:0] FMT_RGB24  = 2'd1;
   localparam logic [1:0] FMT_RGB565 = 2'd2;

   // register indexes on the csr port
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COLOR_RED      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COLOR_GREEN    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COLOR_BLUE     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COLOR_OPACITY  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PIXEL_FORMAT   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALPHA_LOW_BYTE = 3'd5;

   localparam logic [31:0] SPREAD_MASK = 32'h07e0f81f;
   localparam logic [7:0]  FULL_BYTE   = 8'hff;
   localparam logic [5:0]  LEVELS_5BIT = 6'h1f;
   localparam logic [5:0]  LEVELS_6BIT = 6'h3f;

   // 2^23/255 rounded up, exact for every 16-bit dividend
   localparam logic [16:0] RECIP_255 = 17'h08081;

   // per-stage load enables of the pipeline
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } pipe_en_type;

   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [32:0] p;
      p = {17'b0, x} * {16'b0, RECIP_255};
      return p[30:23];
   endfunction

   // c * levels / 255, truncated
   function automatic logic [5:0] quantize(input logic [7:0] c, input logic [5:0] levels);
      logic [15:0] p;
      logic [7:0]  q;
      p = {8'b0, c} * {10'b0, levels};
      q = div255(p);
      return q[5:0];
   endfunction

endpackage

### src/gcpb_alpha.sv
// effective alpha: opacity times coverage over 255, two register stages
module gcpb_alpha (
   input  logic                 clock,
   input  gcpb_pkg::pipe_en_type en,
   input  logic [7:0]           coverage,
   input  logic [7:0]           opacity,
   output logic [7:0]           alpha
);

   logic [15:0] prod_ff;
   logic [15:0] prod_in;
   logic [7:0]  alpha_ff;

   assign prod_in = {8'b0, opacity} * {8'b0, coverage};

   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod_ff <= prod_in;
      end
      if (en.s2) begin
         alpha_ff <= gcpb_pkg::div255(prod_ff);
      end
   end

   assign alpha = alpha_ff;

endmodule

### src/gcpb_mix_lane.sv
// one 8-bit color channel: (fg*a + bg*(255-a))/255 over two stages
module gcpb_mix_lane (
   input  logic                 clock,
   input  gcpb_pkg::pipe_en_type en,
   input  logic [7:0]           fg,
   input  logic [7:0]           bg,
   input  logic [7:0]           alpha,
   output logic [7:0]           result
);

   logic [7:0]  inv_alpha;
   logic [15:0] sum_in;
   logic [15:0] sum_ff;
   logic [7:0]  result_ff;

   assign inv_alpha = gcpb_pkg::FULL_BYTE - alpha;
   assign sum_in    = ({8'b0, fg} * {8'b0, alpha}) + ({8'b0, bg} * {8'b0, inv_alpha});

   always_ff @(posedge clock) begin
      if (en.s3) begin
         sum_ff <= sum_in;
      end
      if (en.s4) begin
         result_ff <= gcpb_pkg::div255(sum_ff);
      end
   end

   assign result = result_ff;

endmodule

### src/gcpb_blend565.sv
// rgb565 packed-field interpolation, spread and scaled term over two stages
module gcpb_blend565 (
   input  logic                 clock,
   input  gcpb_pkg::pipe_en_type en,
   input  logic [15:0]          fg,
   input  logic [15:0]          bg,
   input  logic [7:0]           alpha,
   output logic [31:0]          term,
   output logic [31:0]          base
);

   logic [31:0] fg_spread;
   logic [31:0] bg_spread;
   logic [8:0]  alpha_round;
   logic [31:0] diff_ff;
   logic [5:0]  a5_ff;
   logic [31:0] base3_ff;
   logic [31:0] term_in;
   logic [31:0] term_ff;
   logic [31:0] base4_ff;

   assign fg_spread   = ({16'b0, fg} | {fg, 16'b0}) & gcpb_pkg::SPREAD_MASK;
   assign bg_spread   = ({16'b0, bg} | {bg, 16'b0}) & gcpb_pkg::SPREAD_MASK;
   assign alpha_round = {1'b0, alpha} + 9'd4;

   // product wraps at 32 bits before the shift
   assign term_in = 32'(diff_ff * {26'b0, a5_ff}) >> 5;

   always_ff @(posedge clock) begin
      if (en.s3) begin
         diff_ff  <= fg_spread - bg_spread;
         a5_ff    <= alpha_round[8:3];
         base3_ff <= bg_spread;
      end
      if (en.s4) begin
         term_ff  <= term_in;
         base4_ff <= base3_ff;
      end
   end

   assign term = term_ff;
   assign base = base4_ff;

endmodule

### src/glyph_coverage_pixel_blend.sv
// top level of the glyph coverage pixel blender: csr bank, pipeline control, output stage
// throughput: one transaction per cycle; every stage holds under backpressure
// a stage loads whenever it is empty or the stage after it moves
// reset (synchronous, active high) empties the pipeline and sets the
// registers to red/green/blue 0, opacity 255, 32 bpp, alpha in the low byte
module glyph_coverage_pixel_blend (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_coverage,
   input  logic [31:0] req_background,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pixel,
   output logic        rsp_write_enable,
   // configuration writes
   input  logic        csr_write_enable,
   input  logic [gcpb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]  csr_write_data
);

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [7:0] color_red_ff;
   logic [7:0] color_green_ff;
   logic [7:0] color_blue_ff;
   logic [7:0] color_opacity_ff;
   logic [1:0] pixel_format_ff;
   logic       alpha_low_byte_ff;
   // text color quantized to 565, computed once at write time
   logic [4:0] quant_red_ff;
   logic [5:0] quant_green_ff;
   logic [4:0] quant_blue_ff;

   logic [5:0] quant_red_in;
   logic [5:0] quant_green_in;
   logic [5:0] quant_blue_in;

   assign quant_red_in   = gcpb_pkg::quantize(csr_write_data, gcpb_pkg::LEVELS_5BIT);
   assign quant_green_in = gcpb_pkg::quantize(csr_write_data, gcpb_pkg::LEVELS_6BIT);
   assign quant_blue_in  = gcpb_pkg::quantize(csr_write_data, gcpb_pkg::LEVELS_5BIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         color_red_ff      <= 8'd0;
         color_green_ff    <= 8'd0;
         color_blue_ff     <= 8'd0;
         color_opacity_ff  <= 8'hff;
         pixel_format_ff   <= gcpb_pkg::FMT_ARGB32;
         alpha_low_byte_ff <= 1'b1;
         quant_red_ff      <= 5'd0;
         quant_green_ff    <= 6'd0;
         quant_blue_ff     <= 5'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            gcpb_pkg::CSR_COLOR_RED: begin
               color_red_ff <= csr_write_data;
               quant_red_ff <= quant_red_in[4:0];
            end
            gcpb_pkg::CSR_COLOR_GREEN: begin
               color_green_ff <= csr_write_data;
               quant_green_ff <= quant_green_in;
            end
            gcpb_pkg::CSR_COLOR_BLUE: begin
               color_blue_ff <= csr_write_data;
               quant_blue_ff <= quant_blue_in[4:0];
            end
            gcpb_pkg::CSR_COLOR_OPACITY:  color_opacity_ff  <= csr_write_data;
            gcpb_pkg::CSR_PIXEL_FORMAT:   pixel_format_ff   <= csr_write_data[1:0];
            gcpb_pkg::CSR_ALPHA_LOW_BYTE: alpha_low_byte_ff <= csr_write_data[0];
            default: ; // writes past the register list are dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // pipeline control: one valid bit per stage, loads ripple back
   // from the output so bubbles are squeezed out under backpressure
   // ---------------------------------------------------------------
   logic [4:1] valid_ff;
   logic [4:1] valid_in;
   logic       rsp_valid_ff;
   gcpb_pkg::pipe_en_type en;

   always_comb begin
      en.s5 = !rsp_valid_ff || rsp_ready;
      en.s4 = !valid_ff[4] || en.s5;
      en.s3 = !valid_ff[3] || en.s4;
      en.s2 = !valid_ff[2] || en.s3;
      en.s1 = !valid_ff[1] || en.s2;
   end

   assign req_ready = en.s1;

   always_comb begin
      valid_in[1] = en.s1 ? req_valid   : valid_ff[1];
      valid_in[2] = en.s2 ? valid_ff[1] : valid_ff[2];
      valid_in[3] = en.s3 ? valid_ff[2] : valid_ff[3];
      valid_in[4] = en.s4 ? valid_ff[3] : valid_ff[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (en.s5) begin
            rsp_valid_ff <= valid_ff[4];
         end
      end
   end

   // ---------------------------------------------------------------
   // payload that rides alongside the arithmetic
   // ---------------------------------------------------------------
   logic [31:0] bg1_ff, bg2_ff, bg3_ff, bg4_ff;
   logic        hit1_ff, hit2_ff, hit3_ff, hit4_ff;   // coverage nonzero

   always_ff @(posedge clock) begin
      if (en.s1) begin
         bg1_ff  <= req_background;
         hit1_ff <= (req_coverage != 8'd0);
      end
      if (en.s2) begin
         bg2_ff  <= bg1_ff;
         hit2_ff <= hit1_ff;
      end
      if (en.s3) begin
         bg3_ff  <= bg2_ff;
         hit3_ff <= hit2_ff;
      end
      if (en.s4) begin
         bg4_ff  <= bg3_ff;
         hit4_ff <= hit3_ff;
      end
   end

   // stages 1-2: effective alpha
   logic [7:0] alpha;

   gcpb_alpha u_alpha (
      .clock    (clock),
      .en       (en),
      .coverage (req_coverage),
      .opacity  (color_opacity_ff),
      .alpha    (alpha)
   );

   // stages 3-4: per-channel blend; channel bytes move up one byte when
   // the 32 bpp layout puts alpha in the low byte
   logic       rgba_layout;
   logic [7:0] bg_red, bg_green, bg_blue;
   logic [7:0] mix_red, mix_green, mix_blue;

   assign rgba_layout = (pixel_format_ff == gcpb_pkg::FMT_ARGB32) && alpha_low_byte_ff;
   assign bg_red      = rgba_layout ? bg2_ff[31:24] : bg2_ff[23:16];
   assign bg_green    = rgba_layout ? bg2_ff[23:16] : bg2_ff[15:8];
   assign bg_blue     = rgba_layout ? bg2_ff[15:8]  : bg2_ff[7:0];

   gcpb_mix_lane u_lane_red (
      .clock (clock), .en (en), .fg (color_red_ff), .bg (bg_red),
      .alpha (alpha), .result (mix_red)
   );

   gcpb_mix_lane u_lane_green (
      .clock (clock), .en (en), .fg (color_green_ff), .bg (bg_green),
      .alpha (alpha), .result (mix_green)
   );

   gcpb_mix_lane u_lane_blue (
      .clock (clock), .en (en), .fg (color_blue_ff), .bg (bg_blue),
      .alpha (alpha), .result (mix_blue)
   );

   // stages 3-4: rgb565 interpolation term
   logic [15:0] fg565;
   logic [31:0] term565;
   logic [31:0] base565;

   assign fg565 = {quant_red_ff, quant_green_ff, quant_blue_ff};

   gcpb_blend565 u_blend565 (
      .clock (clock),
      .en    (en),
      .fg    (fg565),
      .bg    (bg2_ff[15:0]),
      .alpha (alpha),
      .term  (term565),
      .base  (base565)
   );

   // ---------------------------------------------------------------
   // stage 5: final add for 565, format select, output register
   // ---------------------------------------------------------------
   logic [31:0] sum565;
   logic [15:0] pix565;
   logic [31:0] pixel_in;
   logic        write_in;
   logic [31:0] pixel_ff;
   logic        write_ff;

   assign sum565 = (term565 + base565) & gcpb_pkg::SPREAD_MASK;
   assign pix565 = sum565[31:16] | sum565[15:0];

   always_comb begin
      unique case (pixel_format_ff)
         gcpb_pkg::FMT_ARGB32: begin
            write_in = hit4_ff;
            if (!hit4_ff) begin
               pixel_in = bg4_ff;
            end else if (alpha_low_byte_ff) begin
               pixel_in = {mix_red, mix_green, mix_blue, gcpb_pkg::FULL_BYTE};
            end else begin
               pixel_in = {gcpb_pkg::FULL_BYTE, mix_red, mix_green, mix_blue};
            end
         end
         gcpb_pkg::FMT_RGB24: begin
            write_in = hit4_ff;
            pixel_in = hit4_ff ? {8'd0, mix_red, mix_green, mix_blue}
                               : {8'd0, bg4_ff[23:0]};
         end
         gcpb_pkg::FMT_RGB565: begin
            write_in = hit4_ff;
            pixel_in = hit4_ff ? {16'd0, pix565} : {16'd0, bg4_ff[15:0]};
         end
         default: begin
            // unused format code: background passes, no write
            write_in = 1'b0;
            pixel_in = bg4_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         pixel_ff <= pixel_in;
         write_ff <= write_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel        = pixel_ff;
   assign rsp_write_enable = write_ff;

endmodule

### src/gcpb_checker.sv
// port-level checks for the glyph coverage pixel blender, bound to the top level
module gcpb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_pixel,
   input logic        rsp_write_enable
);

   // a stalled result holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel)
                                  && $stable(rsp_write_enable))
      else $error("stalled result changed");

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // an empty output stage means every stage can load, so input is open
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("input blocked while output is empty");

   // an open output always lets the pipeline take a new transaction
   assert property (@(posedge clock) disable iff (reset) rsp_ready |-> req_ready)
      else $error("input blocked while output drains");

endmodule

bind glyph_coverage_pixel_blend gcpb_checker u_gcpb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_pixel        (rsp_pixel),
   .rsp_write_enable (rsp_write_enable)
);

### tb/sv/tb.sv
// self-checking testbench for the glyph coverage pixel blender
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD  = 5;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1450;

   // format code the block leaves unused, and register indexes past the bank
   localparam logic [1:0] FMT_UNUSED = 2'd3;
   localparam logic [gcpb_pkg::CSR_INDEX_WIDTH-1:0] CSR_NONE_LO = 3'd6;
   localparam logic [gcpb_pkg::CSR_INDEX_WIDTH-1:0] CSR_NONE_HI = 3'd7;

   // green in the upper half, red and blue in the lower half, gaps between
   localparam logic [31:0] RGB565_SPREAD = 32'h07e0f81f;

   typedef struct packed {
      logic [31:0] pixel;
      logic        write_enable;
   } blend_pixel_type;

   // every input starts at a known value, reset held from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_coverage = 8'h00;
   logic [31:0] req_background = 32'h0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_pixel;
   logic        rsp_write_enable;
   logic        csr_write_enable = 1'b0;
   logic [gcpb_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [7:0]  csr_write_data = 8'h00;

   // shadow copy of the register bank, reset values
   logic [7:0] text_red       = 8'h00;
   logic [7:0] text_green     = 8'h00;
   logic [7:0] text_blue      = 8'h00;
   logic [7:0] text_opacity   = 8'hff;
   logic [1:0] text_format    = gcpb_pkg::FMT_ARGB32;
   logic       text_alpha_low = 1'b1;

   // blended pixels waiting for their rsp transaction, oldest first
   blend_pixel_type expected_blends[$];
   blend_pixel_type oldest_blend;
   int error_count  = 0;
   int req_run_left = 0;
   int rsp_run_left = 0;
   int rsp_hold     = 0;

   glyph_coverage_pixel_blend dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_coverage     (req_coverage),
      .req_background   (req_background),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel        (rsp_pixel),
      .rsp_write_enable (rsp_write_enable),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // idle cycles before the next transaction on one side
   // mostly short, with stretches of back-to-back traffic
   function automatic int draw_wait(inout int run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         run_left = $urandom_range(8, 40);
         return 0;
      end
      if ($urandom_range(0, 2) == 0) return $urandom_range(0, 17);
      return $urandom_range(0, 3);
   endfunction

   // (fg*a + bg*(255-a))/255, truncated
   function automatic logic [7:0] mix_byte(input logic [7:0] fg, input logic [7:0] bg,
                                           input int unsigned a);
      int unsigned sum;
      sum = (32'(fg) * a + 32'(bg) * (32'd255 - a)) / 32'd255;
      return sum[7:0];
   endfunction

   // expected pixel and write flag for one coverage/background pair
   function automatic blend_pixel_type predict_blend(input logic [7:0] cov,
                                                     input logic [31:0] bg);
      blend_pixel_type r;
      int unsigned  a;
      logic [31:0]  a5;
      logic [31:0]  fg565;
      logic [31:0]  fs;
      logic [31:0]  bs;
      logic [31:0]  t;
      a = (32'(text_opacity) * 32'(cov)) / 32'd255;
      r.write_enable = (cov != 8'h00) && (text_format != FMT_UNUSED);
      case (text_format)
         gcpb_pkg::FMT_ARGB32: begin
            if (cov == 8'h00) r.pixel = bg;
            else if (text_alpha_low)
               r.pixel = {mix_byte(text_red, bg[31:24], a), mix_byte(text_green, bg[23:16], a),
                          mix_byte(text_blue, bg[15:8], a), 8'hff};
            else
               r.pixel = {8'hff, mix_byte(text_red, bg[23:16], a),
                          mix_byte(text_green, bg[15:8], a), mix_byte(text_blue, bg[7:0], a)};
         end
         gcpb_pkg::FMT_RGB24: begin
            if (cov == 8'h00) r.pixel = {8'h00, bg[23:0]};
            else
               r.pixel = {8'h00, mix_byte(text_red, bg[23:16], a),
                          mix_byte(text_green, bg[15:8], a), mix_byte(text_blue, bg[7:0], a)};
         end
         gcpb_pkg::FMT_RGB565: begin
            if (cov == 8'h00) begin
               r.pixel = {16'h0, bg[15:0]};
            end else begin
               // quantize the text color, then interpolate all three fields at once
               fg565 = ((32'(text_red) * 32'd31 / 32'd255) << 11)
                     + ((32'(text_green) * 32'd63 / 32'd255) << 5)
                     + (32'(text_blue) * 32'd31 / 32'd255);
               fs = ({16'h0, fg565[15:0]} | {fg565[15:0], 16'h0}) & RGB565_SPREAD;
               bs = ({16'h0, bg[15:0]} | {bg[15:0], 16'h0}) & RGB565_SPREAD;
               a5 = (a + 32'd4) >> 3;
               t = (fs - bs) * a5;
               t = ((t >> 5) + bs) & RGB565_SPREAD;
               r.pixel = {16'h0, t[31:16] | t[15:0]};
            end
         end
         default: r.pixel = bg;
      endcase
      return r;
   endfunction

   // one register write, applied to the shadow bank at the same time
   task automatic csr_write(input logic [gcpb_pkg::CSR_INDEX_WIDTH-1:0] reg_index,
                            input logic [7:0] reg_data);
      csr_write_enable <= 1'b1;
      csr_index        <= reg_index;
      csr_write_data   <= reg_data;
      case (reg_index)
         gcpb_pkg::CSR_COLOR_RED:      text_red       = reg_data;
         gcpb_pkg::CSR_COLOR_GREEN:    text_green     = reg_data;
         gcpb_pkg::CSR_COLOR_BLUE:     text_blue      = reg_data;
         gcpb_pkg::CSR_COLOR_OPACITY:  text_opacity   = reg_data;
         gcpb_pkg::CSR_PIXEL_FORMAT:   text_format    = reg_data[1:0];
         gcpb_pkg::CSR_ALPHA_LOW_BYTE: text_alpha_low = reg_data[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // one req transaction; returns at the edge that accepts it
   task automatic send_pixel(input logic [7:0] cov, input logic [31:0] bg);
      int gap;
      blend_pixel_type want;
      gap  = draw_wait(req_run_left);
      want = predict_blend(cov, bg);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_coverage   <= cov;
      req_background <= bg;
      do @(posedge clock); while (!req_ready);
      expected_blends.push_back(want);
   endtask

   // drop valid, wait for every pending pixel, then let the pipeline drain
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_blends.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   // result side: check each rsp transaction, then stall for a drawn number of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_blends.size() == 0) begin
            $display("%0t: unexpected pixel %h write_enable %b", $time, rsp_pixel,
                     rsp_write_enable);
            error_count++;
         end else begin
            oldest_blend = expected_blends.pop_front();
            if (rsp_pixel !== oldest_blend.pixel) begin
               $display("%0t: pixel expected %h actual %h", $time, oldest_blend.pixel,
                        rsp_pixel);
               error_count++;
            end
            if (rsp_write_enable !== oldest_blend.write_enable) begin
               $display("%0t: write_enable expected %b actual %b", $time,
                        oldest_blend.write_enable, rsp_write_enable);
               error_count++;
            end
         end
         rsp_hold = draw_wait(rsp_run_left);
         rsp_ready <= (rsp_hold == 0);
      end else if (!rsp_ready) begin
         if (rsp_hold > 0) rsp_hold--;
         if (rsp_hold == 0) rsp_ready <= 1'b1;
      end
   end

   // register values straight out of reset: black text, full opacity, rgba layout
   task automatic test_reset_defaults();
      send_pixel(8'hff, 32'h00000000);
      send_pixel(8'h00, 32'hffffffff);   // untouched pixel passes through
      send_pixel(8'h01, 32'ha5a5a5a5);
   endtask

   // argb layout with the alpha byte on top, saturated and mid colors
   task automatic test_32bpp_argb_layout();
      settle();
      csr_write(gcpb_pkg::CSR_COLOR_RED, 8'hff);
      csr_write(gcpb_pkg::CSR_COLOR_GREEN, 8'h00);
      csr_write(gcpb_pkg::CSR_COLOR_BLUE, 8'h80);
      csr_write(gcpb_pkg::CSR_ALPHA_LOW_BYTE, 8'h00);
      send_pixel(8'hff, 32'hffffffff);
      send_pixel(8'h80, 32'h12345678);
      send_pixel(8'h00, 32'h89abcdef);
   endtask

   // nonzero coverage whose effective alpha truncates to zero is still written
   task automatic test_zero_alpha();
      settle();
      csr_write(gcpb_pkg::CSR_COLOR_OPACITY, 8'h00);
      send_pixel(8'hff, 32'h00c0ffee);
      settle();
      csr_write(gcpb_pkg::CSR_COLOR_OPACITY, 8'h01);
      send_pixel(8'hfe, 32'hffffffff);
   endtask

   // packed rgb, top byte of the background dropped
   task automatic test_24bpp();
      settle();
      csr_write(gcpb_pkg::CSR_COLOR_OPACITY, 8'hff);
      csr_write(gcpb_pkg::CSR_PIXEL_FORMAT, {6'h00, gcpb_pkg::FMT_RGB24});
      send_pixel(8'hff, 32'hffffffff);
      send_pixel(8'h00, 32'hffffffff);
      send_pixel(8'h4d, 32'h5a123456);
   endtask

   // rgb565: quantized color, alpha in steps of 1/32, wrap when the text is darker
   task automatic test_565();
      settle();
      csr_write(gcpb_pkg::CSR_COLOR_RED, 8'hff);
      csr_write(gcpb_pkg::CSR_COLOR_GREEN, 8'hff);
      csr_write(gcpb_pkg::CSR_COLOR_BLUE, 8'hff);
      csr_write(gcpb_pkg::CSR_PIXEL_FORMAT, {6'h00, gcpb_pkg::FMT_RGB565});
      send_pixel(8'hff, 32'h00000000);
      send_pixel(8'h03, 32'h0000ffff);   // alpha rounds down to zero steps
      send_pixel(8'h04, 32'h00000000);   // one step of 32
      send_pixel(8'h00, 32'hffffffff);
      send_pixel(8'hc8, 32'hdead1234);
      settle();
      csr_write(gcpb_pkg::CSR_COLOR_RED, 8'h00);
      csr_write(gcpb_pkg::CSR_COLOR_GREEN, 8'h00);
      csr_write(gcpb_pkg::CSR_COLOR_BLUE, 8'h00);
      send_pixel(8'hff, 32'hffffffff);
   endtask

   // format 3, writes past the bank, and data bits above a register's width
   task automatic test_unused_format_and_spare_writes();
      settle();
      csr_write(gcpb_pkg::CSR_PIXEL_FORMAT, {6'h00, FMT_UNUSED});
      send_pixel(8'hff, 32'hffffffff);
      send_pixel(8'h00, 32'h13579bdf);
      settle();
      csr_write(CSR_NONE_LO, 8'hff);
      csr_write(CSR_NONE_HI, 8'h00);
      csr_write(gcpb_pkg::CSR_PIXEL_FORMAT, 8'hfd);      // lands on 24 bpp
      csr_write(gcpb_pkg::CSR_COLOR_GREEN, 8'h7f);
      send_pixel(8'h9c, 32'h00ff00ff);
      settle();
      csr_write(gcpb_pkg::CSR_PIXEL_FORMAT, {6'h3f, gcpb_pkg::FMT_ARGB32});
      csr_write(gcpb_pkg::CSR_ALPHA_LOW_BYTE, 8'hfe);    // lands on alpha in the top byte
      send_pixel(8'hff, 32'h0f0f0f0f);
   endtask

   // random phases: new register settings, then a run of random pixels
   task automatic test_random_blend();
      int sent;
      int phase_len;
      logic [1:0]  fmt_pick;
      logic [7:0]  cov;
      logic [31:0] bg;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         settle();
         // unused format kept rare, the three real ones share the rest
         fmt_pick = ($urandom_range(0, 15) == 0) ? FMT_UNUSED : 2'($urandom_range(0, 2));
         csr_write(gcpb_pkg::CSR_COLOR_RED, pick_level());
         csr_write(gcpb_pkg::CSR_COLOR_GREEN, pick_level());
         csr_write(gcpb_pkg::CSR_COLOR_BLUE, pick_level());
         csr_write(gcpb_pkg::CSR_COLOR_OPACITY, pick_level());
         csr_write(gcpb_pkg::CSR_PIXEL_FORMAT, {6'($urandom), fmt_pick});
         csr_write(gcpb_pkg::CSR_ALPHA_LOW_BYTE, {7'($urandom), 1'($urandom)});
         if ($urandom_range(0, 3) == 0)
            csr_write(($urandom_range(0, 1) == 0) ? CSR_NONE_LO : CSR_NONE_HI, 8'($urandom));
         phase_len = $urandom_range(40, 110);
         repeat (phase_len) begin
            case ($urandom_range(0, 7))
               0: cov = 8'h00;
               1: cov = 8'hff;
               2: cov = 8'($urandom_range(1, 8));
               default: cov = 8'($urandom);
            endcase
            case ($urandom_range(0, 9))
               0: bg = 32'h00000000;
               1: bg = 32'hffffffff;
               default: bg = $urandom;
            endcase
            send_pixel(cov, bg);
            sent++;
         end
      end
   endtask

   // hard stop in case the handshake hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_32bpp_argb_layout();
      test_zero_alpha();
      test_24bpp();
      test_565();
      test_unused_format_and_spare_writes();
      test_random_blend();
      settle();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### glyph_coverage_pixel_blend.f
src/gcpb_pkg.sv
src/gcpb_alpha.sv
src/gcpb_mix_lane.sv
src/gcpb_blend565.sv
src/glyph_coverage_pixel_blend.sv
src/gcpb_checker.sv
tb/sv/tb.sv
